// ===== design/eso_pkg.sv =====
// Shared constants, types and codes for the elevator stop order block.
package eso_pkg;

    localparam int FLOOR_BITS   = 10;
    localparam int MAX_STOPS    = 32;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CURRENT_FLOOR  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION_DOWN = CFG_IDX_BITS'(1);

    // Cell operations
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD       = 2'd0;
    localparam cell_op_t OP_INSERT     = 2'd1;
    localparam cell_op_t OP_TAKE_LEFT  = 2'd2;
    localparam cell_op_t OP_TAKE_RIGHT = 2'd3;

    typedef logic [FLOOR_BITS-1:0] floor_t;

    typedef struct packed {
        logic   valid;
        floor_t value;
    } cell_t;

    // Command broadcast to every cell of a chain
    typedef struct packed {
        cell_op_t op;
        floor_t   value;
    } chain_ctl_t;

    // Status gathered from a chain
    typedef struct packed {
        cell_t head;
        logic  full;
        logic  dup;
    } chain_stat_t;

endpackage

// ===== design/eso_req_if.sv =====
// Request channel: one requested floor per item.
interface eso_req_if;
    logic                 valid;
    logic                 ready;
    eso_pkg::floor_t      floor;
    logic                 last;

    modport source (output valid, output floor, output last, input ready);
    modport sink   (input valid, input floor, input last, output ready);
endinterface

// ===== design/eso_stop_if.sv =====
// Stop channel: one stop in service order per item.
interface eso_stop_if;
    logic                 valid;
    logic                 ready;
    eso_pkg::floor_t      stop_floor;
    logic                 last_stop;
    logic                 no_stop;
    logic                 overflow;

    modport source (output valid, output stop_floor, output last_stop, output no_stop,
                    output overflow, input ready);
    modport sink   (input valid, input stop_floor, input last_stop, input no_stop,
                    input overflow, output ready);
endinterface

// ===== design/eso_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface eso_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [eso_pkg::CFG_IDX_BITS-1:0]   idx;
    logic [eso_pkg::FLOOR_BITS-1:0]     data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== design/eso_cell.sv =====
// One cell of a sorted chain: holds a floor and trades it with its neighbors.
module eso_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  eso_pkg::chain_ctl_t ctl,
    input  eso_pkg::cell_t      left,
    input  logic                left_gt,
    input  eso_pkg::cell_t      right,
    output eso_pkg::cell_t      slot,
    output logic                gt,
    output logic                eq
);

    logic            valid_reg;
    logic            valid_next;
    eso_pkg::floor_t value_reg;
    eso_pkg::floor_t value_next;

    assign slot = {valid_reg, value_reg};
    assign gt = valid_reg && (value_reg > ctl.value);
    assign eq = valid_reg && (value_reg == ctl.value);

    // Pick next content from own value, a neighbor or the broadcast floor
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (ctl.op)
            eso_pkg::OP_INSERT:
            begin
                if (left_gt)
                begin
                    valid_next = left.valid;
                    value_next = left.value;
                end
                else if (left.valid && (!valid_reg || gt))
                begin
                    valid_next = 1'b1;
                    value_next = ctl.value;
                end
            end
            eso_pkg::OP_TAKE_LEFT:
            begin
                valid_next = left.valid;
                value_next = left.value;
            end
            eso_pkg::OP_TAKE_RIGHT:
            begin
                valid_next = right.valid;
                value_next = right.value;
            end
            default:
            begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    // Valid flag clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Floor value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== design/eso_chain.sv =====
// Row of cells forming a sorted store or a stack, with head and status taps.
module eso_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eso_pkg::chain_ctl_t  ctl,
    output eso_pkg::chain_stat_t stat
);

    eso_pkg::cell_t                cells [eso_pkg::MAX_STOPS];
    logic [eso_pkg::MAX_STOPS-1:0] gts;
    logic [eso_pkg::MAX_STOPS-1:0] eqs;

    // Build the row; the left end sees the broadcast floor, the right end sees empty
    for (genvar i = 0; i < eso_pkg::MAX_STOPS; i++)
    begin : g_cell
        eso_pkg::cell_t left_c;
        eso_pkg::cell_t right_c;
        logic           left_gt_c;

        if (i == 0)
        begin : g_first
            assign left_c.valid = 1'b1;
            assign left_c.value = ctl.value;
            assign left_gt_c    = 1'b0;
        end
        else
        begin : g_mid
            assign left_c    = cells[i-1];
            assign left_gt_c = gts[i-1];
        end

        if (i == eso_pkg::MAX_STOPS - 1)
        begin : g_end
            assign right_c.valid = 1'b0;
            assign right_c.value = '0;
        end
        else
        begin : g_inner
            assign right_c = cells[i+1];
        end

        eso_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .left    (left_c),
            .left_gt (left_gt_c),
            .right   (right_c),
            .slot    (cells[i]),
            .gt      (gts[i]),
            .eq      (eqs[i])
        );
    end

    assign stat.head = cells[0];
    assign stat.full = cells[eso_pkg::MAX_STOPS-1].valid;
    assign stat.dup  = |eqs;

endmodule

// ===== design/elevator_stop_order.sv =====
// Top level: collects a batch of floor requests and lists the stops in LOOK order.
// Throughput: one request per cycle while a batch is collected; none during emission.
// After the item marked last, the store is scanned and the stack of floors below the car is
// unwound; an output stall holds each step. The final stop is marked with last_stop, and
// also with no_stop when no floor was held. Reset clears all cell valid bits, the flags,
// the registers (floor 0, direction up) and the output valid; no clearing pass is needed.
module elevator_stop_order (
    input  logic        clk,
    input  logic        rst_n,
    eso_req_if.sink     req,
    eso_stop_if.source  stop,
    eso_cfg_if.sink     cfg
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_POP     = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    eso_pkg::floor_t       cur_floor_reg;
    logic                  dir_down_reg;
    logic                  ovf_seen_reg;
    logic                  ovf_seen_next;
    logic                  ovf_batch_reg;
    logic                  ovf_batch_next;
    logic                  hold_valid_reg;
    eso_pkg::floor_t       hold_value_reg;
    logic                  out_valid_reg;
    eso_pkg::floor_t       out_floor_reg;
    logic                  out_last_reg;
    logic                  out_none_reg;
    logic                  out_ovf_reg;

    eso_pkg::chain_ctl_t   store_ctl;
    eso_pkg::chain_stat_t  store_st;
    eso_pkg::chain_ctl_t   stack_ctl;
    eso_pkg::chain_stat_t  stack_st;

    logic                  req_fire;
    logic                  step_ok;
    logic                  cand_valid;
    eso_pkg::floor_t       cand_value;
    logic                  finish;
    logic                  push_out;

    // Sorted store of requested floors
    eso_chain u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (store_ctl),
        .stat  (store_st)
    );

    // Stack that reverses floors below the car
    eso_chain u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stack_ctl),
        .stat  (stack_st)
    );

    assign req.ready = (state_reg == ST_COLLECT);
    assign req_fire  = req.valid && req.ready;
    assign step_ok   = !out_valid_reg || stop.ready;
    assign push_out  = (cand_valid && hold_valid_reg) || finish;
    assign cfg.ready = 1'b1;

    // Sequencer: insert while collecting, then scan the store and unwind the stack
    always_comb
    begin
        state_next      = state_reg;
        ovf_seen_next   = ovf_seen_reg;
        ovf_batch_next  = ovf_batch_reg;
        store_ctl.op    = eso_pkg::OP_HOLD;
        store_ctl.value = req.floor;
        stack_ctl.op    = eso_pkg::OP_HOLD;
        stack_ctl.value = store_st.head.value;
        cand_valid      = 1'b0;
        cand_value      = store_st.head.value;
        finish          = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                if (req_fire)
                begin
                    if ((req.floor != cur_floor_reg) && !store_st.dup)
                    begin
                        if (store_st.full)
                        begin
                            ovf_seen_next = 1'b1;
                        end
                        else
                        begin
                            store_ctl.op = eso_pkg::OP_INSERT;
                        end
                    end
                    if (req.last)
                    begin
                        ovf_batch_next = ovf_seen_next;
                        ovf_seen_next  = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step_ok)
                begin
                    if (store_st.head.valid)
                    begin
                        if (store_st.head.value < cur_floor_reg)
                        begin
                            store_ctl.op = eso_pkg::OP_TAKE_RIGHT;
                            stack_ctl.op = eso_pkg::OP_TAKE_LEFT;
                        end
                        else if (store_st.head.value == cur_floor_reg)
                        begin
                            store_ctl.op = eso_pkg::OP_TAKE_RIGHT;
                        end
                        else if (dir_down_reg && stack_st.head.valid)
                        begin
                            state_next = ST_POP;
                        end
                        else
                        begin
                            store_ctl.op = eso_pkg::OP_TAKE_RIGHT;
                            cand_valid   = 1'b1;
                        end
                    end
                    else if (stack_st.head.valid)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_POP:
            begin
                if (step_ok)
                begin
                    if (stack_st.head.valid)
                    begin
                        stack_ctl.op = eso_pkg::OP_TAKE_RIGHT;
                        cand_valid   = 1'b1;
                        cand_value   = stack_st.head.value;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (step_ok)
                begin
                    finish     = 1'b1;
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Control state, configuration and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            cur_floor_reg  <= '0;
            dir_down_reg   <= 1'b0;
            ovf_seen_reg   <= 1'b0;
            ovf_batch_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_seen_reg  <= ovf_seen_next;
            ovf_batch_reg <= ovf_batch_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.idx == eso_pkg::REG_CURRENT_FLOOR)
                begin
                    cur_floor_reg <= cfg.data;
                end
                else if (cfg.idx == eso_pkg::REG_DIRECTION_DOWN)
                begin
                    dir_down_reg <= cfg.data[0];
                end
            end
            if (cand_valid)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stop.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold one stop back so the final one can be marked; advance it to the output
    always_ff @(posedge clk)
    begin
        if (cand_valid)
        begin
            hold_value_reg <= cand_value;
        end
        if (push_out)
        begin
            out_floor_reg <= hold_valid_reg ? hold_value_reg : '0;
            out_last_reg  <= finish;
            out_none_reg  <= finish && !hold_valid_reg;
            out_ovf_reg   <= ovf_batch_reg;
        end
    end

    assign stop.valid      = out_valid_reg;
    assign stop.stop_floor = out_floor_reg;
    assign stop.last_stop  = out_last_reg;
    assign stop.no_stop    = out_none_reg;
    assign stop.overflow   = out_ovf_reg;

endmodule
